// File: hw/rtl/mqsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mqsb_pkg;

  // default sizes
  localparam int ENTRIES_DEF = 64;
  localparam int QUEUES_DEF  = 4;

  // fixed field widths
  localparam int QID_W  = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  // input beat
  typedef struct packed {
    logic                     op;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] data_in;
  } in_t;

  // result beat
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data_out;
  } out_t;

endpackage

`default_nettype wire

// File: hw/rtl/multi_queue_shared_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Several FIFO queues kept as linked lists in one shared entry store, with a
// shared free list. An input beat is either an enqueue (queue number and a
// 32-bit word) or a dequeue (queue number); every input beat gives exactly
// one result beat carrying a status (ok, overflow, underflow) and, for a
// successful dequeue, the word. Both channels use valid/ready.
// Each beat has an accept step and an execute step: the accept cycle issues
// the link and payload reads and the tail link write, the next cycle uses
// the read data and does the remaining write back. A new beat is accepted
// only once the previous one has left execute and the skid register is
// empty, as the single read/write port pair of the link memory serializes
// the beats. A result is registered onto out_valid after execute.
// Reset puts every queue empty and chains all entries onto the free list;
// the free list beyond the entries ever handed out is tracked by a fill
// count, so there is no clearing pass and the block is ready right after
// reset. If the receiver stalls, one further result is parked in a skid
// register; input is then held off until the receiver takes a beat.
module multi_queue_shared_buffer_core #(
  parameter int ENTRIES = mqsb_pkg::ENTRIES_DEF,
  parameter int QUEUES  = mqsb_pkg::QUEUES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mqsb_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mqsb_pkg::out_t      out_data
);

  // pointer and index widths; the null pointer is ENTRIES
  localparam int PW   = $clog2(ENTRIES + 1);
  localparam int AW   = $clog2(ENTRIES);
  localparam int QD   = (QUEUES < (1 << mqsb_pkg::QID_W)) ? QUEUES
                                                           : (1 << mqsb_pkg::QID_W);
  localparam int QIW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int QN   = 1 << QIW;
  localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // storage
  logic [PW-1:0]                     link_mem [ENTRIES];
  logic [mqsb_pkg::DATA_W-1:0]       pay_mem  [ENTRIES];

  // control state
  logic                              st_r, st_nxt;
  logic [PW-1:0]                     free_head_r, free_head_nxt;
  logic [PW-1:0]                     fill_r, fill_nxt;
  logic [PW-1:0]                     q_head_r [QN];
  logic [PW-1:0]                     q_tail_r [QN];

  // per-beat registers
  logic                              op_r;
  logic [QIW-1:0]                    qi_r;
  logic [mqsb_pkg::DATA_W-1:0]       word_r;
  logic                              ok_r;
  logic                              head_null_r;
  logic [PW-1:0]                     slot_r;

  // memory read side
  logic [PW-1:0]                     link_rd_r;
  logic                              link_fresh_r;
  logic [PW-1:0]                     link_inc_r;
  logic [mqsb_pkg::DATA_W-1:0]       pay_rd_r;
  logic [PW-1:0]                     link_val;

  // output stage
  logic                              out_valid_r, out_valid_nxt;
  mqsb_pkg::out_t                    out_r, out_nxt;
  logic                              held_r, held_nxt;
  mqsb_pkg::out_t                    skid_r, skid_nxt;
  mqsb_pkg::out_t                    res;

  // accept-side decode
  logic                              acc;
  logic                              q_ok;
  logic [QIW-1:0]                    qi;
  logic [PW-1:0]                     head_sel;
  logic [PW-1:0]                     tail_sel;
  logic                              head_null;
  logic                              enq_ok;
  logic                              deq_ok;
  logic [AW-1:0]                     link_ra;
  logic                              link_we;
  logic [AW-1:0]                     link_wa;
  logic [PW-1:0]                     link_wd;
  logic                              pay_we;

  assign acc       = in_valid && in_ready;
  assign in_ready  = (st_r == ST_IDLE) && !held_r;
  assign q_ok      = 32'(in_data.queue_id) < QUEUES;
  assign qi        = in_data.queue_id[QIW-1:0];
  assign head_sel  = q_ok ? q_head_r[qi] : NULL_PTR;
  assign tail_sel  = q_ok ? q_tail_r[qi] : NULL_PTR;
  assign head_null = !(head_sel < NULL_PTR);
  assign enq_ok    = q_ok && (free_head_r < NULL_PTR);
  assign deq_ok    = q_ok && !head_null;

  // link read address: free head for enqueue, queue head for dequeue
  assign link_ra = (in_data.op == mqsb_pkg::OP_ENQ) ? free_head_r[AW-1:0]
                                                    : head_sel[AW-1:0];

  // untouched free entries link to the next index
  assign link_val = link_fresh_r ? link_inc_r : link_rd_r;

  // link write: tail link on accept, slot link on execute
  always_comb begin
    link_we = 1'b0;
    link_wa = slot_r[AW-1:0];
    link_wd = NULL_PTR;
    if (acc && (in_data.op == mqsb_pkg::OP_ENQ) && enq_ok && !head_null) begin
      link_we = 1'b1;
      link_wa = tail_sel[AW-1:0];
      link_wd = free_head_r;
    end else if ((st_r == ST_EXEC) && ok_r) begin
      link_we = 1'b1;
      link_wa = slot_r[AW-1:0];
      link_wd = (op_r == mqsb_pkg::OP_ENQ) ? NULL_PTR : free_head_r;
    end
  end

  assign pay_we = (st_r == ST_EXEC) && ok_r && (op_r == mqsb_pkg::OP_ENQ);

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_r    <= link_mem[link_ra];
    link_fresh_r <= PW'(link_ra) >= fill_r;
    link_inc_r   <= PW'({1'b0, link_ra} + 1'b1);
  end

  // payload memory
  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[slot_r[AW-1:0]] <= word_r;
    end
    pay_rd_r <= pay_mem[head_sel[AW-1:0]];
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r        <= in_data.op;
      qi_r        <= qi;
      word_r      <= in_data.data_in;
      ok_r        <= (in_data.op == mqsb_pkg::OP_ENQ) ? enq_ok : deq_ok;
      head_null_r <= head_null;
      slot_r      <= (in_data.op == mqsb_pkg::OP_ENQ) ? free_head_r : head_sel;
    end
  end

  // result of the executing beat
  always_comb begin
    res.status   = mqsb_pkg::STAT_OK;
    res.data_out = '0;
    if (!ok_r) begin
      res.status = (op_r == mqsb_pkg::OP_ENQ) ? mqsb_pkg::STAT_OVERFLOW
                                              : mqsb_pkg::STAT_UNDERFLOW;
    end else if (op_r == mqsb_pkg::OP_DEQ) begin
      res.data_out = pay_rd_r;
    end
  end

  // sequencer and free list
  always_comb begin
    st_nxt        = st_r;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          st_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        st_nxt = ST_IDLE;
        if (ok_r) begin
          if (op_r == mqsb_pkg::OP_ENQ) begin
            free_head_nxt = link_val;
            if (slot_r == fill_r) begin
              fill_nxt = PW'(fill_r + 1'b1);
            end
          end else begin
            free_head_nxt = slot_r;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      free_head_r <= '0;
      fill_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // queue head and tail pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QN; i++) begin
        q_head_r[i] <= NULL_PTR;
        q_tail_r[i] <= NULL_PTR;
      end
    end else if ((st_r == ST_EXEC) && ok_r) begin
      if (op_r == mqsb_pkg::OP_ENQ) begin
        if (head_null_r) begin
          q_head_r[qi_r] <= slot_r;
        end
        q_tail_r[qi_r] <= slot_r;
      end else begin
        q_head_r[qi_r] <= link_val;
      end
    end
  end

  // output register with one skid stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    held_nxt      = held_r;
    skid_nxt      = skid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = held_r;
      out_nxt       = skid_r;
      held_nxt      = 1'b0;
    end
    if (st_r == ST_EXEC) begin
      if (!out_valid_r || out_ready) begin
        if (held_r) begin
          held_nxt = 1'b1;
          skid_nxt = res;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = res;
        end
      end else begin
        held_nxt = 1'b1;
        skid_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (st_r == ST_EXEC))
    else $error("accepted beat did not enter execute");

  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EXEC) |=> (st_r == ST_IDLE))
    else $error("execute lasted more than one cycle");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> out_valid_r)
    else $error("skid holds a result while output is empty");

  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == NULL_PTR) |-> (fill_r == NULL_PTR))
    else $error("free list empty before all entries handed out");

  a_link_port: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && link_we) |-> (link_wa != link_ra))
    else $error("tail link write hits the entry being read");

endmodule

`default_nettype wire
